// ===== rtl/core/hsc_pkg.sv =====
`default_nettype none

package hsc_pkg;

  // Field widths
  localparam int unsigned HallW     = 3;
  localparam int unsigned DutyW     = 11;
  localparam int unsigned CompareW  = 10;
  localparam int unsigned SectorW   = 3;
  localparam int unsigned RotationW = 32;
  localparam int unsigned NumPhases = 3;
  localparam int unsigned NumSectors = 6;

  // Stream word widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 72;

  // PWM period and the largest compare the drive can hold
  localparam int unsigned PwmPeriod    = 1000;
  localparam int unsigned CompareMax   = (1 << CompareW) - 1;
  localparam int unsigned DutyLimitInt = (PwmPeriod > CompareMax) ? CompareMax : PwmPeriod;
  localparam logic [CompareW-1:0] DutyLimit = CompareW'(DutyLimitInt);

  // Item kinds
  localparam logic ActHallEdge = 1'b0;
  localparam logic ActDutyCmd  = 1'b1;

  typedef logic [1:0] phase_idx_t;

  // Phase roles per drive step
  localparam phase_idx_t GroundPhaseTab [NumSectors] = '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};
  localparam phase_idx_t FloatPhaseTab  [NumSectors] = '{2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};
  localparam phase_idx_t PwmPhaseTab    [NumSectors] = '{2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

  // Drive step from sector, forward and reverse rotation
  localparam logic [SectorW-1:0] FwdOrderTab [NumSectors] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0};
  localparam logic [SectorW-1:0] RevOrderTab [NumSectors] = '{3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3};

  typedef struct packed {
    logic                    action;
    logic [HallW-1:0]        hall_bits;
    logic signed [DutyW-1:0] duty_command;
  } hsc_item_t;

  typedef struct packed {
    logic [NumPhases-1:0][CompareW-1:0] compare;
    logic [NumPhases-1:0]               enable;
    logic                               stop;
  } hsc_drive_t;

  typedef struct packed {
    logic               valid;
    logic [SectorW-1:0] sector;
  } hsc_hall_t;

  // Map Hall code to sector; codes 0 and 7 are invalid
  function automatic hsc_hall_t hall_decode(input logic [HallW-1:0] code);
    hsc_hall_t res;
    res.valid  = 1'b1;
    res.sector = 3'd0;
    unique case (code)
      3'd1: res.sector = 3'd0;
      3'd2: res.sector = 3'd2;
      3'd3: res.sector = 3'd1;
      3'd4: res.sector = 3'd4;
      3'd5: res.sector = 3'd5;
      3'd6: res.sector = 3'd3;
      default: res.valid = 1'b0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hall_six_step_commutator.sv =====
// Six-step brushless commutator driven by Hall sensor edges.
// Input stream: one word per Hall edge (tuser = 0) or per duty command
// (tuser = 1); tdata carries the Hall code and the signed duty.
// Output stream: one word per input word with the three phase compares,
// the three driver enables, the current sector, the signed rotation
// count and a fault flag for Hall codes 0 and 7 in a decoded word.
// Each word passes through the input register and the state/result
// register. One word per cycle is taken in steady state while the
// receiver does not stall. The next-state logic is a table lookup,
// one 32-bit add and a small compare, between the two registers.
// A duty command is stored and takes effect at the next Hall edge, except
// after a stop (zero duty or reset), when it applies at once using the
// Hall code in the same word.
// Reset floats all phases, clears sector, rotation and duty, and arms the
// immediate update. While the receiver stalls, the result is held, one
// more word is taken into the input register, and then input stalls.
`default_nettype none

module hall_six_step_commutator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [hsc_pkg::InDataW-1:0]   s_axis_tdata_i,  // hall_bits, duty_command
  input  wire logic                          s_axis_tuser_i,  // action
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // compare_u, compare_v, compare_w, enable_u, enable_v, enable_w,
  // sector_now, rotation_count, hall_fault
  output logic [hsc_pkg::OutDataW-1:0]       m_axis_tdata_o
);
  import hsc_pkg::*;

  hsc_item_t item;
  logic      item_valid;
  logic      advance;

  logic                        out_valid_q, out_valid_d;
  logic                        fault_q, fault_d;
  logic [SectorW-1:0]          sector_q, sector_d;
  logic [RotationW-1:0]        rotation_q, rotation_d;
  logic signed [DutyW-1:0]     duty_q, duty_d;
  logic                        rearm_q, rearm_d;
  hsc_drive_t                  drive_q, drive_d;

  hsc_hall_t                   hall;
  hsc_drive_t                  drive_new;
  logic signed [DutyW-1:0]     duty_use;
  logic                        need_decode;
  logic                        apply;
  logic signed [3:0]           diff;
  logic signed [3:0]           delta;

  // Move an item forward once the result slot is free
  assign advance = item_valid && (!out_valid_q || m_axis_tready_i);

  hsc_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .item_o          (item),
    .item_valid_o    (item_valid),
    .item_take_i     (advance)
  );

  // Decode Hall code and pick the duty in force
  assign hall        = hall_decode(item.hall_bits);
  assign duty_use    = (item.action == ActDutyCmd) ? item.duty_command : duty_q;
  assign need_decode = (item.action == ActHallEdge) || rearm_q;
  assign apply       = need_decode && hall.valid;

  hsc_drive u_drive (
    .sector_i (hall.sector),
    .duty_i   (duty_use),
    .drive_o  (drive_new)
  );

  // Shortest signed step between sectors
  always_comb begin
    diff  = signed'({1'b0, hall.sector}) - signed'({1'b0, sector_q});
    delta = diff;
    if (diff <= -4'sd3) begin
      delta = diff + 4'sd6;
    end else if (diff >= 4'sd3) begin
      delta = diff - 4'sd6;
    end
  end

  // Next state
  always_comb begin
    duty_d     = duty_use;
    sector_d   = sector_q;
    rotation_d = rotation_q;
    drive_d    = drive_q;
    rearm_d    = rearm_q;
    fault_d    = need_decode && !hall.valid;
    if (apply) begin
      sector_d   = hall.sector;
      rotation_d = rotation_q + {{(RotationW-4){delta[3]}}, delta};
      drive_d    = drive_new;
      rearm_d    = drive_new.stop;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold state, which is also the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fault_q     <= 1'b0;
      sector_q    <= '0;
      rotation_q  <= '0;
      duty_q      <= '0;
      rearm_q     <= 1'b1;
      drive_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        fault_q    <= fault_d;
        sector_q   <= sector_d;
        rotation_q <= rotation_d;
        duty_q     <= duty_d;
        rearm_q    <= rearm_d;
        drive_q    <= drive_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, fault_q, rotation_q, sector_q,
                            drive_q.enable, drive_q.compare};

`ifndef NO_ASSERTIONS
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sector_q <= 3'd5)
    else $error("sector out of range");

  a_rearm_floats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rearm_q == (drive_q.enable == 3'b000))
    else $error("rearm flag and phase enables disagree");

  a_two_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(drive_q.enable) == 0 || $countones(drive_q.enable) == 2)
    else $error("drive must enable zero or two phases");

  a_fault_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && fault_d |=> sector_q == $past(sector_q) &&
                           rotation_q == $past(rotation_q) &&
                           drive_q == $past(drive_q))
    else $error("faulted item changed sector, rotation or drive");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> $stable(rotation_q) && $stable(drive_q))
    else $error("state changed while result stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/hsc_in_reg.sv =====
`default_nettype none

module hsc_in_reg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [hsc_pkg::InDataW-1:0]  s_axis_tdata_i,  // hall_bits, duty_command
  input  wire logic                         s_axis_tuser_i,  // action
  output hsc_pkg::hsc_item_t                item_o,
  output logic                              item_valid_o,
  input  wire logic                         item_take_i
);
  import hsc_pkg::*;

  logic      valid_q, valid_d;
  hsc_item_t item_q;
  logic      accept;

  // Free when empty or when the held word leaves this cycle
  assign s_axis_tready_o = !valid_q || item_take_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action       <= s_axis_tuser_i;
      item_q.hall_bits    <= s_axis_tdata_i[HallW-1:0];
      item_q.duty_command <= s_axis_tdata_i[HallW+DutyW-1:HallW];
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/hsc_drive.sv =====
`default_nettype none

module hsc_drive (
  input  wire logic [hsc_pkg::SectorW-1:0]     sector_i,
  input  wire logic signed [hsc_pkg::DutyW-1:0] duty_i,
  output hsc_pkg::hsc_drive_t                  drive_o
);
  import hsc_pkg::*;

  logic [DutyW-1:0]    duty_u;
  logic [DutyW-1:0]    mag;
  logic [CompareW-1:0] mag_sat;
  logic [SectorW-1:0]  step;
  phase_idx_t          fp;
  phase_idx_t          pp;

  // Magnitude and saturation to the compare range
  assign duty_u  = duty_i;
  assign mag     = duty_u[DutyW-1] ? (~duty_u + DutyW'(1)) : duty_u;
  assign mag_sat = (mag > {1'b0, DutyLimit}) ? DutyLimit : mag[CompareW-1:0];

  // Pick the drive step from the sector and the direction
  assign step = duty_u[DutyW-1] ? RevOrderTab[sector_i] : FwdOrderTab[sector_i];
  assign fp   = FloatPhaseTab[step];
  assign pp   = PwmPhaseTab[step];

  // Float one phase, ground one, modulate one; float all three on a stop
  always_comb begin
    drive_o.stop        = (duty_i == '0);
    drive_o.compare     = '0;
    drive_o.enable      = '1;
    drive_o.compare[pp] = mag_sat;
    drive_o.enable[fp]  = 1'b0;
    if (drive_o.stop) begin
      drive_o.compare = '0;
      drive_o.enable  = '0;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/hall_six_step_commutator_tb.sv =====
`timescale 1ns / 100ps

module hall_six_step_commutator_tb;
  import hsc_pkg::*;

  localparam int StuckLimit = 2000;
  localparam int DutyCap    = (PwmPeriod > 1023) ? 1023 : PwmPeriod;

  // Rotor geometry: Hall code to sector and back, phase roles per drive step
  localparam logic [2:0] SectorOfCode [6] = '{3'd0, 3'd2, 3'd1, 3'd4, 3'd5, 3'd3};
  localparam logic [2:0] CodeOfSector [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
  localparam logic [1:0] GroundOf     [6] = '{2'd1, 2'd1, 2'd0, 2'd0, 2'd2, 2'd2};
  localparam logic [1:0] FloatOf      [6] = '{2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1};
  localparam logic [1:0] PwmOf        [6] = '{2'd0, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};
  localparam logic [2:0] FwdStep      [6] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd0};
  localparam logic [2:0] RevStep      [6] = '{3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3};

  typedef struct packed {
    logic        fault;
    logic [31:0] rot;
    logic [2:0]  sec;
    logic [2:0]  en;
    logic [2:0][9:0] cmp;
  } drive_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               src_valid = 1'b0;
  logic [InDataW-1:0] src_data = '0;
  logic               src_user = 1'b0;
  logic               sink_ready = 1'b0;
  logic                src_ready;
  logic                out_valid;
  logic [OutDataW-1:0] out_data;

  // Words waiting to go out, and drive words still owed by the block
  hsc_item_t   pending [$];
  drive_word_t drive_due [$];

  // Predicted commutator state
  logic [2:0]        rotor_sec = '0;
  logic [31:0]       rotor_rot = '0;
  logic signed [10:0] duty_r = '0;
  logic              rearm_r = 1'b1;
  logic [2:0][9:0]   phase_cmp = '0;
  logic [2:0]        phase_en = '0;

  logic calm = 1'b0;
  int   mismatches = 0;
  int   src_idle = 0;
  int   sink_stall = 0;
  int   stuck_cycles = 0;

  hall_six_step_commutator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(src_valid),
    .s_axis_tready_o(src_ready),
    .s_axis_tdata_i (src_data),
    .s_axis_tuser_i (src_user),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(sink_ready),
    .m_axis_tdata_o (out_data)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic report(input string msg);
    if (mismatches < 100) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Decode a Hall code and advance sector and rotation; false on codes 0 and 7
  function automatic bit advance_rotor(input logic [2:0] code);
    logic [2:0] nxt;
    int delta;
    if (code == 3'd0 || code == 3'd7) return 1'b0;
    nxt = SectorOfCode[code - 3'd1];
    delta = int'(nxt) - int'(rotor_sec);
    if (delta <= -3) delta += 6;
    else if (delta >= 3) delta -= 6;
    rotor_rot = rotor_rot + 32'(delta);
    rotor_sec = nxt;
    return 1'b1;
  endfunction

  // Recompute the three phase drives from sector and stored duty
  function automatic void update_phases();
    logic [2:0] stp;
    logic [1:0] fp, gp, pp;
    int mag;
    rearm_r = 1'b0;
    if (duty_r == 0) begin
      phase_cmp = '0;
      phase_en = '0;
      rearm_r = 1'b1;
      return;
    end
    if (duty_r > 0) begin
      stp = FwdStep[rotor_sec];
      mag = int'(duty_r);
    end else begin
      stp = RevStep[rotor_sec];
      mag = -int'(duty_r);
    end
    if (mag > DutyCap) mag = DutyCap;
    fp = FloatOf[stp];
    gp = GroundOf[stp];
    pp = PwmOf[stp];
    phase_cmp[fp] = '0;
    phase_en[fp] = 1'b0;
    phase_cmp[gp] = '0;
    phase_en[gp] = 1'b1;
    phase_cmp[pp] = 10'(mag);
    phase_en[pp] = 1'b1;
  endfunction

  // Apply one accepted word to the predicted state and return the drive word
  function automatic drive_word_t commutate(input logic act, input logic [2:0] hall,
                                            input logic [10:0] duty);
    drive_word_t res;
    logic fault;
    fault = 1'b0;
    if (act == ActHallEdge) begin
      if (advance_rotor(hall)) update_phases();
      else fault = 1'b1;
    end else begin
      duty_r = duty;
      if (rearm_r) begin
        if (advance_rotor(hall)) update_phases();
        else fault = 1'b1;
      end
    end
    res.cmp = phase_cmp;
    res.en = phase_en;
    res.sec = rotor_sec;
    res.rot = rotor_rot;
    res.fault = fault;
    return res;
  endfunction

  task automatic queue_word(input logic act, input logic [2:0] hall, input logic [10:0] duty);
    hsc_item_t it;
    it.action = act;
    it.hall_bits = hall;
    it.duty_command = duty;
    pending.push_back(it);
  endtask

  // Spin a rotor: mostly clean Hall sequences, some duty changes, some noise
  task automatic queue_run(input int n);
    int r, step, pos, dir;
    logic [10:0] duty;
    pos = rotor_sec;
    dir = 1;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), 11'($urandom));
      end else if (r < 28) begin
        r = $urandom_range(0, 9);
        if (r == 0) duty = '0;
        else if (r == 1) duty = 11'($urandom);
        else duty = 11'($urandom_range(1, 1000));
        if ($urandom_range(0, 1) != 0 && r > 1) duty = -duty;
        queue_word(ActDutyCmd, CodeOfSector[pos], duty);
      end else begin
        if ($urandom_range(0, 19) == 0) dir = -dir;
        r = $urandom_range(0, 99);
        if (r < 5) step = 2 * dir;
        else if (r < 8) step = 3;
        else step = dir;
        pos = (pos + step + 6) % 6;
        queue_word(ActHallEdge, CodeOfSector[pos], 11'($urandom));
      end
    end
  endtask

  // Hold until the block has nothing in flight
  task automatic wait_drained();
    while (pending.size() != 0 || src_valid || drive_due.size() != 0) @(negedge clk_i);
  endtask

  // Drive input words; idle only between words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_idle <= 0;
    end else begin
      if (src_valid && src_ready) begin
        drive_due.push_back(commutate(src_user, src_data[2:0], src_data[13:3]));
      end
      if (!src_valid || src_ready) begin
        if (src_idle != 0) begin
          src_valid <= 1'b0;
          src_idle <= src_idle - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_valid <= 1'b0;
          src_idle <= $urandom_range(0, 2);
        end else if (pending.size() != 0) begin
          hsc_item_t it;
          it = pending.pop_front();
          src_data <= {2'b00, it.duty_command, it.hall_bits};
          src_user <= it.action;
          src_valid <= 1'b1;
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Take output words, check each against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      sink_stall <= 0;
    end else begin
      if (out_valid && sink_ready) begin
        if (drive_due.size() == 0) begin
          report("output word with nothing expected");
        end else begin
          drive_word_t want;
          want = drive_due.pop_front();
          for (int p = 0; p < 3; p++) begin
            if (out_data[p*10 +: 10] != want.cmp[p])
              report($sformatf("compare[%0d] got %0d expected %0d", p,
                               out_data[p*10 +: 10], want.cmp[p]));
            if (out_data[30 + p] !== want.en[p])
              report($sformatf("enable[%0d] got %b expected %b", p,
                               out_data[30 + p], want.en[p]));
          end
          if (out_data[35:33] !== want.sec)
            report($sformatf("sector got %0d expected %0d", out_data[35:33], want.sec));
          if (out_data[67:36] !== want.rot)
            report($sformatf("rotation got %0d expected %0d",
                             $signed(out_data[67:36]), $signed(want.rot)));
          if (out_data[68] !== want.fault)
            report($sformatf("hall fault got %b expected %b", out_data[68], want.fault));
        end
      end
      if (sink_stall != 0) begin
        sink_ready <= 1'b0;
        sink_stall <= sink_stall - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_ready <= 1'b0;
        sink_stall <= $urandom_range(0, 2);
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk_i) begin
    if ((src_valid && src_ready) || (out_valid && sink_ready)) begin
      stuck_cycles <= 0;
    end else if (rst_ni) begin
      if (stuck_cycles >= StuckLimit) begin
        $display("hall_six_step_commutator_tb: errors");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: stopped drive, faults, rearm, saturation, wrap of the sector delta
    queue_word(ActHallEdge, 3'd1, 11'sd0);
    queue_word(ActHallEdge, 3'd0, 11'sd5);
    queue_word(ActDutyCmd, 3'd7, 11'sd500);
    queue_word(ActDutyCmd, 3'd3, 11'sd1023);
    queue_word(ActDutyCmd, 3'd0, -11'sd1024);
    queue_word(ActHallEdge, 3'd2, 11'sd0);
    queue_word(ActHallEdge, 3'd5, 11'sd0);
    queue_word(ActHallEdge, 3'd2, 11'h7FF);
    queue_word(ActHallEdge, 3'd7, 11'sd0);
    queue_word(ActDutyCmd, 3'd1, 11'sd1);
    queue_word(ActHallEdge, 3'd6, 11'sd0);
    queue_word(ActDutyCmd, 3'd4, 11'sd0);
    queue_word(ActHallEdge, 3'd4, 11'sd0);
    queue_word(ActDutyCmd, 3'd5, -11'sd1);
    queue_word(ActDutyCmd, 3'd1, 11'sd1000);
    queue_word(ActHallEdge, 3'd1, 11'sd0);
    queue_word(ActHallEdge, 3'd3, 11'sd0);
    queue_word(ActHallEdge, 3'd2, 11'sd0);
    queue_word(ActHallEdge, 3'd6, 11'sd0);
    queue_word(ActHallEdge, 3'd4, 11'sd0);
    queue_word(ActHallEdge, 3'd5, 11'sd0);
    queue_word(ActDutyCmd, 3'd0, 11'sd1001);
    queue_word(ActHallEdge, 3'd1, 11'sd0);
    queue_word(ActDutyCmd, 3'd6, -11'sd1000);
    queue_word(ActHallEdge, 3'd5, 11'sd0);
    wait_drained();

    // Random spin with idling on both sides
    queue_run(950);
    wait_drained();

    // Final stretch at full rate
    calm <= 1'b1;
    queue_run(150);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("hall_six_step_commutator_tb: clean");
    end else begin
      $display("hall_six_step_commutator_tb: errors");
    end
    $finish;
  end

endmodule
